[rtl/hkrp_pkg.sv]
// Package with the shared constants, codes and types of the HID key report packer.
`default_nettype none

package hkrp_pkg;

  // Queue and report geometry.
  localparam int QUEUE_DEPTH = 64;
  localparam int REPORT_KEYS = 6;
  localparam int OUT_SLOTS   = 6;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;

  // Register reset values.
  localparam logic [15:0] RESET_INTERVAL   = 16'd10;
  localparam logic [15:0] RESET_FIRST_FIRE = 16'd1010;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL   = 1'b0,
    REG_FIRST_FIRE = 1'b1
  } reg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_PACK
  } state_t;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] key;
  } pair_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef struct packed {
    logic clear;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/hkrp_key_cell.sv]
// One key slot of the report chain: holds a key and flags a match against the candidate.
`default_nettype none

module hkrp_key_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hkrp_pkg::cell_ctrl_t ctrl,
  input  wire logic [7:0]         cand_key,
  input  wire logic               prev_full,
  output logic                    full,
  output logic [7:0]              key,
  output logic                    hit
);
  import hkrp_pkg::*;

  // The first empty slot in the chain takes the candidate.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (ctrl.clear) begin
      full <= 1'b0;
    end else if (ctrl.load && prev_full && !full) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      key <= 8'd0;
    end else if (ctrl.load && prev_full && !full) begin
      key <= cand_key;
    end
  end

  assign hit = full && (key == cand_key);

endmodule

`default_nettype wire

[rtl/hkrp_pair_fifo.sv]
// Pair queue: a memory with head, tail and fill count; head_pair is a registered read of the head entry.
`default_nettype none

module hkrp_pair_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire hkrp_pkg::pair_t     push_pair,
  input  wire logic                pop,
  output hkrp_pkg::pair_t          head_pair,
  output hkrp_pkg::fifo_status_t   status
);
  import hkrp_pkg::*;

  pair_t              mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0]  head;
  logic [QIDX_W-1:0]  head_next;
  logic [QIDX_W-1:0]  tail;
  logic [QFILL_W-1:0] fill;

  function automatic logic [QIDX_W-1:0] wrap_inc(input logic [QIDX_W-1:0] idx);
    logic [QIDX_W-1:0] res;
    if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + QIDX_W'(1);
    end
    return res;
  endfunction

  assign status.empty = (fill == '0);
  assign status.full  = (fill == QFILL_W'(QUEUE_DEPTH));

  always_comb begin
    head_next = head;
    if (pop && !status.empty) begin
      head_next = wrap_inc(head);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      if (push && !status.full) begin
        tail <= wrap_inc(tail);
      end
      if (push && !status.full && !(pop && !status.empty)) begin
        fill <= fill + QFILL_W'(1);
      end else if (pop && !status.empty && !(push && !status.full)) begin
        fill <= fill - QFILL_W'(1);
      end
    end
  end

  // Write at the tail; read ahead at the next head so head_pair tracks the head.
  always_ff @(posedge clk) begin
    if (push && !status.full) begin
      mem[tail] <= push_pair;
    end
    head_pair <= mem[head_next];
  end

endmodule

`default_nettype wire

[rtl/hid_key_report_packer.sv]
// Top level of the HID key report packer: control, millisecond timer and key slot chain.
//
//  Channel   Ports                                             Handshake
//  -------   -----------------------------------------------   ------------------------------
//  command   start, busy, operation, push_modifier, push_key   taken when start && !busy
//  result    done, report_modifier, key_0..key_5,              done high for one cycle
//            key_count, is_release
//  config    cfg_write, cfg_index, cfg_data                    written when cfg_write is high
//
// A push item, a tick that does not act, a tick that sends a release report and a tick
// that finds the queue empty leave busy low.
// A tick that packs a key report raises busy while the queue memory gives up one pair
// per cycle to the key slot chain, up to six keys, and then sends the report.
// The result appears in the cycle after the item finishes, for one cycle; the receiver
// cannot stall it.
// Reset is synchronous and needs no clearing pass; the queue memory is read every cycle,
// but a head pair is used only while the queue is not empty.
`default_nettype none

module hid_key_report_packer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation,
  input  wire logic [7:0]                    push_modifier,
  input  wire logic [7:0]                    push_key,
  output logic                               done,
  output logic [7:0]                         report_modifier,
  output logic [7:0]                         key_0,
  output logic [7:0]                         key_1,
  output logic [7:0]                         key_2,
  output logic [7:0]                         key_3,
  output logic [7:0]                         key_4,
  output logic [7:0]                         key_5,
  output logic [2:0]                         key_count,
  output logic                               is_release,
  input  wire logic                          cfg_write,
  input  wire logic [hkrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import hkrp_pkg::*;

  // Control state.
  state_t      state;
  state_t      state_next;
  logic [15:0] interval;
  logic [15:0] ticks;
  logic [15:0] ticks_next;
  logic        release_pending;
  logic        release_pending_next;
  logic [7:0]  last_modifier;
  logic [7:0]  last_modifier_next;
  logic [7:0]  pack_mod;
  logic [7:0]  pack_mod_next;
  logic [2:0]  take_cnt;
  logic [2:0]  take_cnt_next;

  // Queue interface.
  logic         fifo_push;
  logic         fifo_pop;
  pair_t        head_pair;
  pair_t        in_pair;
  fifo_status_t fstat;

  // Key slot chain.
  cell_ctrl_t  cell_ctrl;
  logic [7:0]  cell_key  [REPORT_KEYS];
  logic        cell_full [REPORT_KEYS];
  logic        cell_hit  [REPORT_KEYS];
  logic [REPORT_KEYS-1:0] hit_vec;
  logic        any_hit;
  logic [7:0]  slot_key  [OUT_SLOTS];

  // Result strobes.
  logic        emit_release;
  logic        emit_keys;
  logic        take;
  logic [7:0]  cur_mod;

  assign in_pair.modifier = push_modifier;
  assign in_pair.key      = push_key;

  hkrp_pair_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_pair (in_pair),
    .pop       (fifo_pop),
    .head_pair (head_pair),
    .status    (fstat)
  );

  // Each cell sees whether its left neighbor is full, so the head key lands in the
  // first free slot and keys stay in queue order.
  for (genvar c = 0; c < REPORT_KEYS; c++) begin : g_cell
    logic left_full;
    if (c == 0) begin : g_first
      assign left_full = 1'b1;
    end else begin : g_rest
      assign left_full = cell_full[c-1];
    end

    hkrp_key_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .cand_key  (head_pair.key),
      .prev_full (left_full),
      .full      (cell_full[c]),
      .key       (cell_key[c]),
      .hit       (cell_hit[c])
    );

    assign hit_vec[c] = cell_hit[c];
  end

  assign any_hit = |hit_vec;

  // Report slots past the configured key count always read as zero.
  for (genvar s = 0; s < OUT_SLOTS; s++) begin : g_slot
    if (s < REPORT_KEYS) begin : g_used
      assign slot_key[s] = cell_key[s];
    end else begin : g_unused
      assign slot_key[s] = 8'd0;
    end
  end

  assign busy = (state == ST_PACK);

  // The first pair of a report sets the modifier that the rest must match.
  assign cur_mod = (take_cnt == 3'd0) ? head_pair.modifier : pack_mod;
  assign take    = (take_cnt < 3'(REPORT_KEYS)) && !fstat.empty &&
                   (head_pair.modifier == cur_mod) && !any_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      ticks           <= RESET_FIRST_FIRE;
      release_pending <= 1'b1;
      last_modifier   <= 8'd0;
      take_cnt        <= 3'd0;
    end else begin
      state           <= state_next;
      ticks           <= ticks_next;
      release_pending <= release_pending_next;
      last_modifier   <= last_modifier_next;
      take_cnt        <= take_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pack_mod <= pack_mod_next;
  end

  // Configuration registers. The first firing time only reloads the countdown, which
  // is handled with the next-state logic below, so it needs no register of its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= RESET_INTERVAL;
    end else if (cfg_write && (reg_index_t'(cfg_index) == REG_INTERVAL)) begin
      interval <= cfg_data;
    end
  end

  always_comb begin
    state_next           = state;
    ticks_next           = ticks;
    release_pending_next = release_pending;
    last_modifier_next   = last_modifier;
    pack_mod_next        = pack_mod;
    take_cnt_next        = take_cnt;
    fifo_push            = 1'b0;
    fifo_pop             = 1'b0;
    cell_ctrl            = '0;
    emit_release         = 1'b0;
    emit_keys            = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (op_t'(operation) == OP_PUSH) begin
            fifo_push = 1'b1;
          end else if (ticks > 16'd1) begin
            ticks_next = ticks - 16'd1;
          end else begin
            // Acting tick: reload the countdown, then send a release or, with pairs queued, pack keys.
            ticks_next = interval;
            if (release_pending) begin
              emit_release         = 1'b1;
              release_pending_next = 1'b0;
            end else if (!fstat.empty) begin
              cell_ctrl.clear = 1'b1;
              take_cnt_next   = 3'd0;
              state_next      = ST_PACK;
            end
          end
        end
      end
      ST_PACK: begin
        if (take) begin
          cell_ctrl.load = 1'b1;
          fifo_pop       = 1'b1;
          take_cnt_next  = take_cnt + 3'd1;
          pack_mod_next  = cur_mod;
        end else begin
          emit_keys            = 1'b1;
          last_modifier_next   = pack_mod;
          release_pending_next = 1'b1;
          state_next           = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Writing the first firing time restarts the countdown from it.
    if (cfg_write && (reg_index_t'(cfg_index) == REG_FIRST_FIRE)) begin
      ticks_next = cfg_data;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit_release || emit_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_release) begin
      report_modifier <= last_modifier;
      key_0           <= 8'd0;
      key_1           <= 8'd0;
      key_2           <= 8'd0;
      key_3           <= 8'd0;
      key_4           <= 8'd0;
      key_5           <= 8'd0;
      key_count       <= 3'd0;
      is_release      <= 1'b1;
    end else if (emit_keys) begin
      report_modifier <= pack_mod;
      key_0           <= slot_key[0];
      key_1           <= slot_key[1];
      key_2           <= slot_key[2];
      key_3           <= slot_key[3];
      key_4           <= slot_key[4];
      key_5           <= slot_key[5];
      key_count       <= take_cnt;
      is_release      <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/hkrp_checker.sv]
// Port-level checker for the HID key report packer, bound to the top level.
`default_nettype none

module hkrp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [7:0] key_0,
  input wire logic [7:0] key_1,
  input wire logic [7:0] key_2,
  input wire logic [7:0] key_3,
  input wire logic [7:0] key_4,
  input wire logic [7:0] key_5,
  input wire logic [2:0] key_count,
  input wire logic       is_release
);
  import hkrp_pkg::*;

  // A result is only shown once the block has gone idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_release_empty: assert property (@(posedge clk) disable iff (rst)
    done && is_release |-> key_count == 3'd0 && key_0 == 8'd0 && key_1 == 8'd0 &&
      key_2 == 8'd0 && key_3 == 8'd0 && key_4 == 8'd0 && key_5 == 8'd0)
    else $error("release report carries keys");

  a_key_count: assert property (@(posedge clk) disable iff (rst)
    done && !is_release |-> key_count != 3'd0 && key_count <= 3'(REPORT_KEYS))
    else $error("key report count out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    done && !is_release |->
      (key_count > 3'd1 || key_1 == 8'd0) && (key_count > 3'd2 || key_2 == 8'd0) &&
      (key_count > 3'd3 || key_3 == 8'd0) && (key_count > 3'd4 || key_4 == 8'd0) &&
      (key_count > 3'd5 || key_5 == 8'd0))
    else $error("unused key slot is not zero");

endmodule

bind hid_key_report_packer hkrp_checker u_hkrp_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .done       (done),
  .key_0      (key_0),
  .key_1      (key_1),
  .key_2      (key_2),
  .key_3      (key_3),
  .key_4      (key_4),
  .key_5      (key_5),
  .key_count  (key_count),
  .is_release (is_release)
);

`default_nettype wire

[test/hid_key_report_checker.sv]
// Checker for the HID key report packer: predicts reports from accepted items and compares them.
`timescale 1ns / 1ps

module hid_key_report_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic                            operation,
  input  wire logic [7:0]                      push_modifier,
  input  wire logic [7:0]                      push_key,
  input  wire logic                            done,
  input  wire logic [7:0]                      report_modifier,
  input  wire logic [7:0]                      key_0,
  input  wire logic [7:0]                      key_1,
  input  wire logic [7:0]                      key_2,
  input  wire logic [7:0]                      key_3,
  input  wire logic [7:0]                      key_4,
  input  wire logic [7:0]                      key_5,
  input  wire logic [2:0]                      key_count,
  input  wire logic                            is_release,
  input  wire logic                            cfg_write,
  input  wire logic [hkrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                     cfg_data,
  output int                                   failures,
  output int                                   outstanding,
  output int                                   reports_checked
);
  import hkrp_pkg::*;

  typedef struct packed {
    logic [7:0]      modifier;
    logic [5:0][7:0] keys;
    logic [2:0]      count;
    logic            is_rel;
  } report_t;

  // Shadow copy of the block's registers and state.
  logic [15:0] interval;
  logic [15:0] countdown;
  bit          release_due;
  logic [7:0]  held_modifier;
  pair_t       pairs[$];
  report_t     reports_due[$];

  initial begin
    failures = 0;
    outstanding = 0;
    reports_checked = 0;
  end

  // Advances the shadow state by one millisecond tick and tells whether a report goes out.
  function automatic bit next_report(output report_t rpt);
    logic [7:0] mod;
    int n;
    bit blocked;
    rpt = '0;
    n = 0;
    blocked = 1'b0;
    if (countdown > 16'd1) begin
      countdown--;
      return 1'b0;
    end
    countdown = interval;
    if (release_due) begin
      release_due = 1'b0;
      rpt.modifier = held_modifier;
      rpt.is_rel = 1'b1;
      return 1'b1;
    end
    if (pairs.size() == 0) return 1'b0;
    mod = pairs[0].modifier;
    // Take up to six pairs while they share the head's modifier and bring a key not yet in the report.
    while (!blocked && n < REPORT_KEYS && pairs.size() != 0) begin
      if (pairs[0].modifier != mod) blocked = 1'b1;
      for (int j = 0; j < n; j++)
        if (rpt.keys[j] == pairs[0].key) blocked = 1'b1;
      if (!blocked) begin
        rpt.keys[n] = pairs[0].key;
        n++;
        void'(pairs.pop_front());
      end
    end
    rpt.modifier = mod;
    rpt.count = 3'(n);
    held_modifier = mod;
    release_due = 1'b1;
    return 1'b1;
  endfunction

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    report_t got;
    report_t want;
    report_t rpt;
    if (rst) begin
      interval = RESET_INTERVAL;
      countdown = RESET_FIRST_FIRE;
      release_due = 1'b1;
      held_modifier = 8'h00;
      pairs.delete();
      reports_due.delete();
    end else begin
      // Results are matched before this edge's item, which can only add later ones.
      if (done) begin
        got.modifier = report_modifier;
        got.keys = {key_5, key_4, key_3, key_2, key_1, key_0};
        got.count = key_count;
        got.is_rel = is_release;
        if (reports_due.size() == 0) begin
          failures++;
          $display("%0t: report with none expected, expected nothing, actual %0h", $time, got);
        end else begin
          want = reports_due.pop_front();
          reports_checked++;
          compare_field("report_modifier", want.modifier, got.modifier);
          for (int s = 0; s < OUT_SLOTS; s++)
            compare_field($sformatf("key_%0d", s), want.keys[s], got.keys[s]);
          compare_field("key_count", 8'(want.count), 8'(got.count));
          compare_field("is_release", 8'(want.is_rel), 8'(got.is_rel));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_INTERVAL:   interval = cfg_data;
          REG_FIRST_FIRE: countdown = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (operation == OP_PUSH) begin
          if (pairs.size() < QUEUE_DEPTH) pairs.push_back({push_modifier, push_key});
        end else if (next_report(rpt)) begin
          reports_due.push_back(rpt);
        end
      end
    end
    outstanding = reports_due.size();
  end

endmodule

[test/hid_key_report_packer_test.sv]
// Testbench top for the HID key report packer: item and register stimulus plus the verdict.
`timescale 1ns / 1ps

module hid_key_report_packer_test;
  import hkrp_pkg::*;

  // The slowest legal run is roughly 1400 items, each with its idle gap, plus the settling
  // pauses between register settings; the limit leaves ample margin.
  localparam int CYCLE_LIMIT   = 300000;
  // Long enough for a packing tick to finish and its report to follow.
  localparam int SETTLE_CYCLES = 12;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  operation;
  logic [7:0]            push_modifier;
  logic [7:0]            push_key;
  logic                  done;
  logic [7:0]            report_modifier;
  logic [7:0]            key_0;
  logic [7:0]            key_1;
  logic [7:0]            key_2;
  logic [7:0]            key_3;
  logic [7:0]            key_4;
  logic [7:0]            key_5;
  logic [2:0]            key_count;
  logic                  is_release;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]           cfg_data;

  int failures;
  int outstanding;
  int reports_checked;
  int pushes_sent = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  int cycles = 0;
  // Chance in percent that an item is preceded by an idle burst.
  int gap_pct = 0;

  hid_key_report_packer DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .push_modifier   (push_modifier),
    .push_key        (push_key),
    .done            (done),
    .report_modifier (report_modifier),
    .key_0           (key_0),
    .key_1           (key_1),
    .key_2           (key_2),
    .key_3           (key_3),
    .key_4           (key_4),
    .key_5           (key_5),
    .key_count       (key_count),
    .is_release      (is_release),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // The checker sits beside the block and sees exactly the same pins.
  hid_key_report_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .push_modifier   (push_modifier),
    .push_key        (push_key),
    .done            (done),
    .report_modifier (report_modifier),
    .key_0           (key_0),
    .key_1           (key_1),
    .key_2           (key_2),
    .key_3           (key_3),
    .key_4           (key_4),
    .key_5           (key_5),
    .key_count       (key_count),
    .is_release      (is_release),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .failures        (failures),
    .outstanding     (outstanding),
    .reports_checked (reports_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a report that never arrives ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d reports still due.", outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Modifiers cluster on a few common masks so that runs of equal modifiers form,
  // with a fully random mask now and then to exercise every bit.
  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'h02;
      2:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A narrow key pool makes repeated keys likely, which cuts a report short.
  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(4, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  // Presents one item at a falling edge and holds it until the block takes it. The task
  // returns at a falling edge with start still high, so that a following item keeps start
  // asserted without a drop in between.
  task automatic issue(op_t op, logic [7:0] m, logic [7:0] k);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    push_modifier <= m;
    push_key <= k;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (op == OP_PUSH) pushes_sent++;
    else ticks_sent++;
  endtask

  // Waits until every predicted report has been seen and the block has gone quiet.
  task automatic settle();
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Registers are only written with the block idle; both are written each time, which
  // also restarts the countdown to the first report action.
  task automatic set_config(logic [15:0] interval_val, logic [15:0] first_fire_val);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_INTERVAL;
    cfg_data <= interval_val;
    @(negedge clk);
    cfg_index <= REG_FIRST_FIRE;
    cfg_data <= first_fire_val;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Random traffic made mostly of well-formed typing: bursts of pairs that share a
  // modifier, runs of ticks that drain them, an occasional flood that overruns the
  // queue, and some items with every field random.
  task automatic random_traffic(int target);
    int sent;
    int kind;
    int len;
    logic [7:0] group_mod;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 47) begin
        len = $urandom_range(1, 8);
        group_mod = pick_modifier();
        repeat (len)
          issue(OP_PUSH, ($urandom_range(0, 3) == 0) ? pick_modifier() : group_mod,
                pick_key());
        sent += len;
      end else if (kind < 94) begin
        len = $urandom_range(1, 10);
        repeat (len) issue(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        sent += len;
      end else if (kind == 94) begin
        len = $urandom_range(60, 70);
        group_mod = pick_modifier();
        repeat (len) issue(OP_PUSH, group_mod, 8'($urandom_range(0, 255)));
        sent += len;
      end else begin
        issue(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = OP_PUSH;
    push_modifier = 8'h00;
    push_key = 8'h00;
    cfg_write = 1'b0;
    cfg_index = REG_INTERVAL;
    cfg_data = 16'h0000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A zero interval acts like one, and a zero first-fire count makes
    // the very first tick act.
    set_config(16'd0, 16'd0);
    // After reset a release is pending, so the first action is a release with modifier 0.
    issue(OP_TICK, 8'h00, 8'h00);
    // Empty queue with nothing to release: no report at all.
    issue(OP_TICK, 8'hFF, 8'hFF);
    // All-ones and all-zeros pairs; their modifiers differ, so they go out separately.
    issue(OP_PUSH, 8'hFF, 8'hFF);
    issue(OP_PUSH, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);
    // Seven keys with one modifier: the first report is capped at six keys.
    for (int k = 1; k <= 7; k++) issue(OP_PUSH, 8'hA5, 8'(k));
    issue(OP_TICK, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);
    // A repeated key ends a report early and starts the next one.
    issue(OP_PUSH, 8'h5A, 8'h09);
    issue(OP_PUSH, 8'h5A, 8'h09);
    issue(OP_PUSH, 8'h5A, 8'h0A);
    issue(OP_TICK, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);
    issue(OP_TICK, 8'h00, 8'h00);

    // Random part, one phase per register setting.
    gap_pct = 20;
    set_config(16'd1, 16'd0);
    random_traffic(300);

    gap_pct = 10;
    set_config(16'($urandom_range(2, 6)), 16'($urandom_range(0, 30)));
    random_traffic(150);
    // Hold the sender back until every report due so far has been seen.
    settle();
    random_traffic(150);

    // Longest interval: one action early on and none afterwards, so pushed pairs pile up in the queue.
    gap_pct = 30;
    set_config(16'hFFFF, 16'd3);
    random_traffic(40);

    // Longest first-fire count: the countdown never runs out within this phase.
    set_config(16'd1, 16'hFFFF);
    random_traffic(40);

    gap_pct = 30;
    set_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 5)));
    random_traffic(300);

    // Final stretch at full rate, with no idle cycles from the sender.
    gap_pct = 0;
    set_config(16'd2, 16'd1);
    random_traffic(400);

    settle();
    $display("Sent %0d push and %0d tick items over %0d register settings,",
             pushes_sent, ticks_sent, settings_used);
    $display("including queue overflow and capped and cut-short reports; %0d reports checked.",
             reports_checked);
    if (failures == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
